// ===== sv/hdsp_pkg.sv =====
// Shared types and constants for the hex/decimal suffix parser.
package hdsp_pkg;

    localparam int TEXT_W  = 8;
    localparam int VALUE_W = 32;
    // Character position counter; counts up to 15, above the default MAX_CHARS of 11
    localparam int POS_W   = 4;

    // Parse mode codes
    localparam logic [1:0] MODE_DEC    = 2'd0;
    localparam logic [1:0] MODE_HEX    = 2'd1;
    localparam logic [1:0] MODE_ACCEPT = 2'd2;
    localparam logic [1:0] MODE_BAD    = 2'd3;

    // Characters of interest
    localparam logic [TEXT_W-1:0] CHR_NUL  = 8'h00;
    localparam logic [TEXT_W-1:0] CHR_ZERO = 8'h30;
    localparam logic [TEXT_W-1:0] CHR_LA   = 8'h61;
    localparam logic [TEXT_W-1:0] CHR_UA   = 8'h41;

    // Suffix shift amounts
    localparam int KILO_SHIFT = 10;
    localparam int MEGA_SHIFT = 20;

    typedef struct packed {
        logic [1:0]         mode;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] acc;
        logic               first_zero;
    } hdsp_state_t;

    localparam hdsp_state_t STATE_RESET = '{
        mode:       MODE_DEC,
        pos:        '0,
        acc:        '0,
        first_zero: 1'b0
    };

endpackage

// ===== sv/hdsp_if.sv =====
// Valid/ready channel interfaces for text input and parse results.
interface hdsp_text_if
    import hdsp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface hdsp_result_if
    import hdsp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               valid_res;

    modport source (output valid, output value, output valid_res, input ready);
    modport sink   (input valid, input value, input valid_res, output ready);
endinterface

// ===== sv/hex_or_decimal_suffix_parser_core.sv =====
// Top level: streaming parser of hex (0x) or decimal (k/m suffix) text to a 32-bit value.
// A terminating zero byte reaches the output through the input register, then the
// result register. Throughput: one text word per cycle unless a terminator waits on
// a full result slot; the state update lies between the two registers.
// Reset (rst_n low, asynchronous): pipeline empty, parse state at start of string.
module hex_or_decimal_suffix_parser_core
    import hdsp_pkg::*;
#(
    parameter int MAX_CHARS = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    hdsp_text_if.sink     char_stream,
    hdsp_result_if.source result
);

    // input register
    logic              in_vld_reg;
    logic              in_vld_next;
    logic [TEXT_W-1:0] in_byte_reg;

    // parse state
    hdsp_state_t st_reg;
    hdsp_state_t st_next;

    // result register
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_ok_reg;

    logic               emit;
    logic [VALUE_W-1:0] res_value;
    logic               res_ok;
    logic               advance;
    logic               in_take;

    hdsp_step #(
        .MAX_CHARS (MAX_CHARS)
    ) u_step (
        .text_byte (in_byte_reg),
        .cur       (st_reg),
        .nxt       (st_next),
        .emit      (emit),
        .res_value (res_value),
        .res_ok    (res_ok)
    );

    // Held word moves on unless it is a terminator and the result slot stays full.
    assign advance = in_vld_reg && (!emit || !out_vld_reg || result.ready);

    // Input register refills in the same cycle it drains.
    assign char_stream.ready = !in_vld_reg || advance;
    assign in_take           = char_stream.valid && char_stream.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance && emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= STATE_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= char_stream.text_byte;
        end
        if (advance && emit)
        begin
            out_value_reg <= res_value;
            out_ok_reg    <= res_ok;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.value     = out_value_reg;
    assign result.valid_res = out_ok_reg;

endmodule

// ===== sv/hdsp_step.sv =====
// Next-state and result logic for one text byte.
module hdsp_step
    import hdsp_pkg::*;
#(
    parameter int MAX_CHARS = 11
)
(
    input  logic [TEXT_W-1:0]  text_byte,
    input  hdsp_state_t        cur,
    output hdsp_state_t        nxt,
    output logic               emit,
    output logic [VALUE_W-1:0] res_value,
    output logic               res_ok
);

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CHARS);
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HEX   = POS_W'(2);

    logic [POS_W-1:0]   pos_inc;
    logic [3:0]         dec_digit;
    logic [3:0]         hex_digit;
    logic               is_dec;
    logic               is_hex;
    logic               is_x;
    logic               is_k;
    logic               is_m;
    logic [VALUE_W-1:0] acc_x10;
    logic               ok;
    logic [TEXT_W-1:0]  lc_off;
    logic [TEXT_W-1:0]  uc_off;
    logic [TEXT_W-1:0]  dc_off;

    assign pos_inc = cur.pos + POS_ONE;
    assign dc_off  = text_byte - CHR_ZERO;
    assign lc_off  = text_byte - CHR_LA;
    assign uc_off  = text_byte - CHR_UA;

    // character classes
    always_comb
    begin
        is_dec = text_byte inside {[8'h30:8'h39]};
        is_x   = text_byte inside {8'h78, 8'h58};
        is_k   = text_byte inside {8'h6b, 8'h4b};
        is_m   = text_byte inside {8'h6d, 8'h4d};
        is_hex = 1'b1;
        dec_digit = dc_off[3:0];
        if (is_dec)
        begin
            hex_digit = dc_off[3:0];
        end
        else if (text_byte inside {[8'h61:8'h66]})
        begin
            hex_digit = lc_off[3:0] + 4'd10;
        end
        else if (text_byte inside {[8'h41:8'h46]})
        begin
            hex_digit = uc_off[3:0] + 4'd10;
        end
        else
        begin
            hex_digit = 4'd0;
            is_hex    = 1'b0;
        end
    end

    // acc * 10 as (acc << 3) + (acc << 1), modulo 2^32
    assign acc_x10 = {cur.acc[VALUE_W-4:0], 3'b000} + {cur.acc[VALUE_W-2:0], 1'b0};

    assign ok = (cur.mode != MODE_BAD);

    always_comb
    begin
        nxt       = cur;
        emit      = 1'b0;
        res_value = '0;
        res_ok    = 1'b0;
        if (text_byte == CHR_NUL)
        begin
            emit      = 1'b1;
            res_ok    = ok;
            res_value = ok ? cur.acc : '0;
            nxt       = STATE_RESET;
        end
        else
        begin
            case (cur.mode)
                MODE_DEC:
                begin
                    if (cur.pos == POS_ONE && cur.first_zero && is_x)
                    begin
                        nxt.mode = MODE_HEX;
                        nxt.pos  = POS_HEX;
                    end
                    else if (is_k && cur.pos != '0)
                    begin
                        nxt.acc  = cur.acc << KILO_SHIFT;
                        nxt.mode = MODE_ACCEPT;
                    end
                    else if (is_m && cur.pos != '0)
                    begin
                        nxt.acc  = cur.acc << MEGA_SHIFT;
                        nxt.mode = MODE_ACCEPT;
                    end
                    else if (is_dec)
                    begin
                        if (cur.pos == '0 && text_byte == CHR_ZERO)
                        begin
                            nxt.first_zero = 1'b1;
                        end
                        nxt.acc = acc_x10 + VALUE_W'(dec_digit);
                        nxt.pos = pos_inc;
                        if (pos_inc >= POS_LIMIT)
                        begin
                            nxt.mode = MODE_BAD;
                        end
                    end
                    else
                    begin
                        nxt.mode = MODE_BAD;
                    end
                end
                MODE_HEX:
                begin
                    if (cur.pos >= POS_LIMIT || !is_hex)
                    begin
                        nxt.mode = MODE_BAD;
                    end
                    else
                    begin
                        nxt.acc = {cur.acc[VALUE_W-5:0], hex_digit};
                        nxt.pos = pos_inc;
                    end
                end
                MODE_ACCEPT:
                begin
                    nxt = cur;
                end
                default:
                begin
                    nxt.mode = MODE_BAD;
                end
            endcase
        end
    end

endmodule
